// ----- hdl/hgpc_pkg.sv -----
// Shared constants and direction tables for the hexagon grid point-to-cell pipeline.
// No dependencies; imported by the pipeline modules and the checker.
package hgpc_pkg;

    // Result cell number width; the count wraps at this many bits.
    localparam int CELL_BITS  = 17;
    // Fraction bits of the sqrt(3) constant.
    localparam int SQRT3_BITS = 24;
    // round(sqrt(3) * 2^24), held as a 25-bit magnitude.
    localparam logic [24:0] SQRT3_Q = 25'd29058991;

    typedef logic [2:0] t_seg;
    typedef logic signed [2:0] t_dir;

    // Ring direction of each segment, x in halves of the pitch.
    function automatic t_dir ring_x2(input t_seg j);
        t_dir r;
        unique case (j)
            3'd0: r = 3'sd2;
            3'd1: r = 3'sd1;
            3'd2: r = -3'sd1;
            3'd3: r = -3'sd2;
            3'd4: r = -3'sd1;
            default: r = 3'sd1;
        endcase
        return r;
    endfunction

    // Ring direction of each segment, y in units of sqrt(3)/2.
    function automatic t_dir ring_yh(input t_seg j);
        t_dir r;
        unique case (j)
            3'd0: r = 3'sd0;
            3'd1: r = -3'sd1;
            3'd2: r = -3'sd1;
            3'd3: r = 3'sd0;
            3'd4: r = 3'sd1;
            default: r = 3'sd1;
        endcase
        return r;
    endfunction

    // Step along a segment, x in halves of the pitch.
    function automatic t_dir step_x2(input t_seg j);
        t_dir r;
        unique case (j)
            3'd0: r = -3'sd1;
            3'd1: r = -3'sd2;
            3'd2: r = -3'sd1;
            3'd3: r = 3'sd1;
            3'd4: r = 3'sd2;
            default: r = 3'sd1;
        endcase
        return r;
    endfunction

    // Step along a segment, y in units of sqrt(3)/2.
    function automatic t_dir step_yh(input t_seg j);
        t_dir r;
        unique case (j)
            3'd0: r = -3'sd1;
            3'd1: r = 3'sd0;
            3'd2: r = 3'sd1;
            3'd3: r = 3'sd1;
            3'd4: r = 3'sd0;
            default: r = -3'sd1;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/hgpc_cand.sv -----
// Candidate cell test: centre of one candidate cell and the hexagon containment check.
// Depends on hgpc_pkg for the direction tables and the sqrt(3) scale.
module hgpc_cand #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 8
) (
    input  logic signed [INT_BITS+2:0]          i_cm,
    input  hgpc_pkg::t_seg                      i_cj,
    input  logic signed [INT_BITS+2:0]          i_cl,
    input  logic signed [INT_BITS+FRAC_BITS-1:0] i_x,
    input  logic signed [INT_BITS+FRAC_BITS+25:0] i_t,
    output logic                                o_pass,
    output logic signed [INT_BITS+5:0]          o_cx2,
    output logic signed [INT_BITS+5:0]          o_kyh
);
    import hgpc_pkg::*;

    localparam int IN = INT_BITS + FRAC_BITS;
    localparam int S  = FRAC_BITS + SQRT3_BITS;
    localparam int WW = IN + SQRT3_BITS + 4;
    localparam int DW = INT_BITS + 6;

    logic signed [WW-1:0] xh, dx, dt, k3, one;

    // Centre of the candidate in half-pitch x and sqrt(3)/2 y units.
    always_comb begin
        o_cx2 = DW'(i_cm) * DW'(ring_x2(i_cj)) + DW'(i_cl) * DW'(step_x2(i_cj));
        o_kyh = DW'(i_cm) * DW'(ring_yh(i_cj)) + DW'(i_cl) * DW'(step_yh(i_cj));
    end

    // Residual in the (x, sqrt3*y) plane and the six-sided test against one.
    always_comb begin
        one = WW'(1) <<< S;
        xh  = WW'(i_x) <<< SQRT3_BITS;
        dx  = xh - (WW'(o_cx2) <<< (S - 1));
        k3  = (WW'(o_kyh) <<< 1) + WW'(o_kyh);
        dt  = WW'(i_t) - (k3 <<< (S - 1));
        o_pass = (dt - dx <= one) && (-(dx <<< 1) <= one) && (-dt - dx <= one)
              && (dx - dt <= one) && ((dx <<< 1) <= one) && (dt + dx <= one);
    end

endmodule

// ----- hdl/hex_grid_point_to_cell.sv -----
// Top level of the hexagon grid point-to-cell pipeline.
// Depends on hgpc_pkg and hgpc_cand.
//
// Maps a signed fixed-point point to its spiral hexagon cell number and the offset from
// that cell's centre. The block is an eight-stage pipeline that can take one item every
// cycle while the output is not blocked. Each stage holds its item only while the stage
// after it is full and blocked, so bubbles close up under back-pressure and input ready
// drops only when all eight stages hold items. When no candidate cell contains the point,
// not_found is set with cell 1 and zero offsets.
module hex_grid_point_to_cell #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [INT_BITS+FRAC_BITS-1:0]       i_x_pos,
    input  logic [INT_BITS+FRAC_BITS-1:0]       i_y_pos,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hgpc_pkg::CELL_BITS-1:0]      o_cell_number,
    output logic [FRAC_BITS:0]                  o_x_offset,
    output logic [FRAC_BITS:0]                  o_y_offset,
    output logic                                o_not_found
);
    import hgpc_pkg::*;

    localparam int IN  = INT_BITS + FRAC_BITS;
    localparam int S   = FRAC_BITS + SQRT3_BITS;
    localparam int TW  = IN + 26;
    localparam int WW  = IN + SQRT3_BITS + 4;
    localparam int N   = INT_BITS + 2;
    localparam int K   = N + 2;
    localparam int R   = (2 ** K + 2) / 3;
    localparam int MW  = INT_BITS + 1;
    localparam int CW  = INT_BITS + 3;
    localparam int DW  = INT_BITS + 6;
    localparam int PW  = DW + 26;
    localparam int OW  = FRAC_BITS + 1;
    localparam int OYW = FRAC_BITS + SQRT3_BITS + 1;
    localparam int NST = 8;

    logic [NST:1] r_v;
    logic [NST:1] adv;

    // Stage advance: a stage loads when it is empty or the next stage loads.
    always_comb begin
        adv[NST] = ~r_v[NST] | i_ready;
        for (int k = NST - 1; k >= 1; k--) begin
            adv[k] = ~r_v[k] | adv[k+1];
        end
    end

    assign o_ready = adv[1];
    assign o_valid = r_v[NST];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: scale y by sqrt(3).
    logic signed [IN-1:0] r_s1_x, r_s1_y;
    logic signed [TW-1:0] r_s1_t;
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_x <= $signed(i_x_pos);
            r_s1_y <= $signed(i_y_pos);
            r_s1_t <= TW'($signed(i_y_pos)) * TW'($signed({1'b0, SQRT3_Q}));
        end
    end

    // Stage 2: largest of the six projections picks the segment.
    logic signed [WW-1:0] s2_xh, s2_a, s2_b, s2_best;
    logic signed [WW-1:0] s2_p [6];
    t_seg s2_j;
    always_comb begin
        s2_xh = WW'(r_s1_x) <<< SQRT3_BITS;
        s2_a  = (s2_xh <<< 1) + s2_xh;
        s2_b  = WW'(r_s1_t);
        s2_p[0] = s2_a - s2_b;
        s2_p[1] = -(s2_b <<< 1);
        s2_p[2] = -s2_a - s2_b;
        s2_p[3] = s2_b - s2_a;
        s2_p[4] = s2_b <<< 1;
        s2_p[5] = s2_a + s2_b;
        s2_best = '0;
        s2_j    = '0;
        for (int i = 0; i < 6; i++) begin
            if (s2_p[i] > s2_best) begin
                s2_best = s2_p[i];
                s2_j    = t_seg'(i);
            end
        end
    end

    logic signed [IN-1:0] r_s2_x, r_s2_y;
    logic signed [TW-1:0] r_s2_t;
    logic signed [WW-1:0] r_s2_best;
    t_seg r_s2_j;
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_t    <= r_s1_t;
            r_s2_best <= s2_best;
            r_s2_j    <= s2_j;
        end
    end

    // Stage 3: ring by division by three through a reciprocal, and the in-segment position.
    logic [N+K-1:0]       s3_qr;
    logic [MW-1:0]        s3_m;
    logic signed [WW-1:0] s3_xh, s3_t, s3_lp;
    always_comb begin
        s3_qr = (N + K)'(r_s2_best[S +: N]) * (N + K)'(R);
        s3_m  = s3_qr[K +: MW];
        s3_xh = WW'(r_s2_x) <<< SQRT3_BITS;
        s3_t  = WW'(r_s2_t);
        unique case (r_s2_j)
            3'd0: s3_lp = -s3_xh - s3_t;
            3'd1: s3_lp = -(s3_xh <<< 1);
            3'd2: s3_lp = s3_t - s3_xh;
            3'd3: s3_lp = s3_xh + s3_t;
            3'd4: s3_lp = s3_xh <<< 1;
            default: s3_lp = s3_xh - s3_t;
        endcase
    end

    logic signed [IN-1:0] r_s3_x, r_s3_y;
    logic signed [TW-1:0] r_s3_t;
    logic [MW-1:0]        r_s3_m;
    logic signed [WW-1:0] r_s3_lp;
    t_seg r_s3_j;
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s3_x  <= r_s2_x;
            r_s3_y  <= r_s2_y;
            r_s3_t  <= r_s2_t;
            r_s3_m  <= s3_m;
            r_s3_lp <= s3_lp;
            r_s3_j  <= r_s2_j;
        end
    end

    // Stage 4: cell index along the segment and the three candidates.
    logic signed [WW-1:0] s4_sum, s4_lw;
    logic signed [CW-1:0] s4_m, s4_l;
    logic signed [CW-1:0] s4_cm [3];
    logic signed [CW-1:0] s4_cl [3];
    t_seg                 s4_cj [3];
    always_comb begin
        s4_m   = CW'($signed({1'b0, r_s3_m}));
        s4_sum = r_s3_lp + ((WW'(s4_m) + WW'(1)) <<< S);
        s4_lw  = s4_sum >>> (S + 1);
        s4_l   = s4_lw[CW-1:0];
        s4_cm[0] = s4_m;
        s4_cm[1] = s4_m + CW'(1);
        s4_cm[2] = s4_m + CW'(1);
        s4_cl[0] = s4_l;
        s4_cl[1] = s4_l;
        s4_cl[2] = s4_l + CW'(1);
        for (int i = 0; i < 3; i++) begin
            s4_cj[i] = r_s3_j;
            // A cell at the end of a segment is the first cell of the next one.
            if (s4_cl[i] == s4_cm[i]) begin
                s4_cl[i] = '0;
                s4_cj[i] = (r_s3_j == 3'd5) ? 3'd0 : r_s3_j + 3'd1;
            end
        end
    end

    logic signed [IN-1:0] r_s4_x, r_s4_y;
    logic signed [TW-1:0] r_s4_t;
    logic signed [CW-1:0] r_s4_cm [3];
    logic signed [CW-1:0] r_s4_cl [3];
    t_seg                 r_s4_cj [3];
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s4_x  <= r_s3_x;
            r_s4_y  <= r_s3_y;
            r_s4_t  <= r_s3_t;
            r_s4_cm <= s4_cm;
            r_s4_cl <= s4_cl;
            r_s4_cj <= s4_cj;
        end
    end

    // Stage 5: hexagon test of each candidate.
    logic                 s5_pass [3];
    logic signed [DW-1:0] s5_cx2  [3];
    logic signed [DW-1:0] s5_kyh  [3];
    for (genvar g = 0; g < 3; g++) begin : g_cand
        hgpc_cand #(
            .FRAC_BITS(FRAC_BITS),
            .INT_BITS (INT_BITS)
        ) u_cand (
            .i_cm  (r_s4_cm[g]),
            .i_cj  (r_s4_cj[g]),
            .i_cl  (r_s4_cl[g]),
            .i_x   (r_s4_x),
            .i_t   (r_s4_t),
            .o_pass(s5_pass[g]),
            .o_cx2 (s5_cx2[g]),
            .o_kyh (s5_kyh[g])
        );
    end

    logic signed [IN-1:0] r_s5_x, r_s5_y;
    logic                 r_s5_pass [3];
    logic signed [DW-1:0] r_s5_cx2  [3];
    logic signed [DW-1:0] r_s5_kyh  [3];
    logic signed [CW-1:0] r_s5_cm   [3];
    logic signed [CW-1:0] r_s5_cl   [3];
    t_seg                 r_s5_cj   [3];
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s5_x    <= r_s4_x;
            r_s5_y    <= r_s4_y;
            r_s5_pass <= s5_pass;
            r_s5_cx2  <= s5_cx2;
            r_s5_kyh  <= s5_kyh;
            r_s5_cm   <= r_s4_cm;
            r_s5_cl   <= r_s4_cl;
            r_s5_cj   <= r_s4_cj;
        end
    end

    // Stage 6: the last candidate that passes wins.
    logic [1:0] s6_sel;
    logic       s6_found;
    always_comb begin
        s6_found = 1'b1;
        priority if (r_s5_pass[2]) begin
            s6_sel = 2'd2;
        end else if (r_s5_pass[1]) begin
            s6_sel = 2'd1;
        end else if (r_s5_pass[0]) begin
            s6_sel = 2'd0;
        end else begin
            s6_sel   = 2'd0;
            s6_found = 1'b0;
        end
    end

    logic signed [IN-1:0] r_s6_x, r_s6_y;
    logic                 r_s6_found;
    logic signed [DW-1:0] r_s6_cx2, r_s6_kyh;
    logic signed [CW-1:0] r_s6_cm, r_s6_cl;
    t_seg                 r_s6_cj;
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r_s6_x     <= r_s5_x;
            r_s6_y     <= r_s5_y;
            r_s6_found <= s6_found;
            r_s6_cx2   <= r_s5_cx2[s6_sel];
            r_s6_kyh   <= r_s5_kyh[s6_sel];
            r_s6_cm    <= r_s5_cm[s6_sel];
            r_s6_cl    <= r_s5_cl[s6_sel];
            r_s6_cj    <= r_s5_cj[s6_sel];
        end
    end

    // Stage 7: products for the centre y and the cell count, and the x offset.
    logic signed [IN-1:0]   r_s7_y;
    logic                   r_s7_found;
    logic signed [PW-1:0]   r_s7_prod;
    logic signed [2*CW-1:0] r_s7_mm1;
    logic signed [CW+3:0]   r_s7_mj;
    logic signed [CW-1:0]   r_s7_cm, r_s7_cl;
    logic [OW-1:0]          r_s7_ox;
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r_s7_y     <= r_s6_y;
            r_s7_found <= r_s6_found;
            r_s7_prod  <= PW'(r_s6_kyh) * PW'($signed({1'b0, SQRT3_Q}));
            r_s7_mm1   <= (2 * CW)'(r_s6_cm) * (2 * CW)'(r_s6_cm - CW'(1));
            r_s7_mj    <= (CW + 4)'(r_s6_cm) * (CW + 4)'($signed({1'b0, r_s6_cj}));
            r_s7_cm    <= r_s6_cm;
            r_s7_cl    <= r_s6_cl;
            r_s7_ox    <= OW'(r_s6_x) - (OW'(r_s6_cx2) << (FRAC_BITS - 1));
        end
    end

    // Stage 8: spiral cell number and rounded y offset.
    logic [CELL_BITS-1:0] s8_mm1, s8_cell;
    logic [OYW-1:0]       s8_oy;
    always_comb begin
        s8_mm1 = CELL_BITS'(r_s7_mm1);
        if (r_s7_cm == '0) begin
            s8_cell = CELL_BITS'(1);
        end else begin
            s8_cell = CELL_BITS'(2) + s8_mm1 + (s8_mm1 << 1) + CELL_BITS'(r_s7_mj)
                    + CELL_BITS'(r_s7_cl);
        end
        s8_oy = (OYW'(r_s7_y) << SQRT3_BITS) - (OYW'(r_s7_prod) << (FRAC_BITS - 1))
              + (OYW'(1) << (SQRT3_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            o_not_found <= ~r_s7_found;
            if (r_s7_found) begin
                o_cell_number <= s8_cell;
                o_x_offset    <= r_s7_ox;
                o_y_offset    <= s8_oy[SQRT3_BITS +: OW];
            end else begin
                o_cell_number <= CELL_BITS'(1);
                o_x_offset    <= '0;
                o_y_offset    <= '0;
            end
        end
    end

endmodule

// ----- hdl/hgpc_check.sv -----
// Port-level checker for the hexagon grid point-to-cell pipeline, with its bind.
// Depends on hgpc_pkg and the top level hex_grid_point_to_cell.
module hgpc_check #(
    parameter int FRAC_BITS = 16,
    parameter int INT_BITS  = 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [hgpc_pkg::CELL_BITS-1:0] o_cell_number,
    input logic [FRAC_BITS:0]             o_x_offset,
    input logic [FRAC_BITS:0]             o_y_offset,
    input logic                           o_not_found
);
    import hgpc_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_cell_number) && $stable(o_x_offset)
                                && $stable(o_y_offset) && $stable(o_not_found))
        else $error("stalled result changed");

    // Input is refused only when the pipeline is full and the output is blocked.
    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input refused with room in the pipeline");

    // A miss always reports the origin cell with zero offset.
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_found |-> o_cell_number == CELL_BITS'(1)
                                   && o_x_offset == '0 && o_y_offset == '0)
        else $error("miss with nonzero fields");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result present after reset");

endmodule

bind hex_grid_point_to_cell hgpc_check #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
) u_hgpc_check (.*);
